// ===== rtl/bisection_square_root_macros.svh =====
// Assertion macros shared by the square root pipeline modules.
// Defining NO_ASSERTIONS turns every check into an empty statement.
`ifndef BISECTION_SQUARE_ROOT_MACROS_SVH
`define BISECTION_SQUARE_ROOT_MACROS_SVH

`ifndef NO_ASSERTIONS
// When ante holds, cons must hold in the same cycle.
`define BSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("square root check failed: same-cycle implication");
// When ante holds, cons must hold in the next cycle.
`define BSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("square root check failed: next-cycle implication");
`else
`define BSR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BSR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/bsr_pkg.sv =====
// Types and constants of the bisection square root pipeline.
// No dependencies; every module file imports it.
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    localparam int DATA_W = 32;
    localparam int SQ_W   = 2 * DATA_W;

    // Search bounds travelling between steps; x is the radicand.
    typedef struct packed {
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] x;
    } bnd_t;

    // Midpoint and its exact square, with the bounds it came from.
    typedef struct packed {
        logic [DATA_W-1:0] mid;
        logic [SQ_W-1:0]   sq;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] x;
    } mid_t;

endpackage

`default_nettype wire

// ===== rtl/bisection_square_root.sv =====
// Bisection square root of an unsigned fixed-point radicand.
//
// Channels: radicand (radicand_valid / radicand_ready) carries one radicand
// per beat; root (root_valid / root_ready) returns one root per radicand, in
// order. Both use a valid/ready handshake; a beat moves when both are high.
// Throughput: one radicand per cycle while the skid entry is empty. Each
// bisection step is two register stages, midpoint plus exact 32x32 square,
// then compare and bound update; the last step stops after its midpoint.
// Path to root_valid: input register, 2*ITERATIONS-1 step stages and the
// output register, set by the one-multiplier-per-stage split.
// Stalls: a stalled root beat holds in the output register; one more beat
// parks in a skid entry, and only then does the whole pipeline freeze and
// radicand_ready drop. Nothing is lost or repeated.
// Reset: rst_n clears every valid bit; the block is ready during and after
// reset and keeps no state between items.
// Depends on bsr_pkg, bsr_mid_stage, bsr_cmp_stage and bsr_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module bisection_square_root
    import bsr_pkg::*;
#(
    parameter int ITERATIONS    = 13,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              radicand_valid,
    output logic                   radicand_ready,
    input  wire logic [DATA_W-1:0] radicand,
    output logic                   root_valid,
    input  wire logic              root_ready,
    output logic [DATA_W-1:0]      root
);

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

    logic pipe_en;
    logic bnd_v [ITERATIONS];
    bnd_t bnd_d [ITERATIONS];
    logic mid_v [ITERATIONS];
    mid_t mid_d [ITERATIONS];

    logic init_valid_reg;
    bnd_t init_data_reg;
    bnd_t init_data_next;

    // Starting bounds depend on whether the radicand exceeds one.
    always_comb
    begin
        init_data_next.x = radicand;
        if (radicand > ONE)
        begin
            init_data_next.lo = '0;
            init_data_next.hi = radicand;
        end
        else
        begin
            init_data_next.lo = radicand;
            init_data_next.hi = ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            init_valid_reg <= radicand_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            init_data_reg <= init_data_next;
        end
    end

    assign radicand_ready = pipe_en;
    assign bnd_v[0]       = init_valid_reg;
    assign bnd_d[0]       = init_data_reg;

    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_step
        bsr_mid_stage u_mid (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (pipe_en),
            .in_v  (bnd_v[k]),
            .in_d  (bnd_d[k]),
            .out_v (mid_v[k]),
            .out_d (mid_d[k])
        );
        if (k < ITERATIONS - 1)
        begin : g_cmp
            bsr_cmp_stage #(
                .FRACTION_BITS (FRACTION_BITS)
            ) u_cmp (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (pipe_en),
                .in_v  (mid_v[k]),
                .in_d  (mid_d[k]),
                .out_v (bnd_v[k+1]),
                .out_d (bnd_d[k+1])
            );
        end
    end

    bsr_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .tail_v    (mid_v[ITERATIONS-1]),
        .tail_d    (mid_d[ITERATIONS-1].mid),
        .pipe_en   (pipe_en),
        .out_valid (root_valid),
        .out_data  (root),
        .out_ready (root_ready)
    );

endmodule

`default_nettype wire

// ===== rtl/bsr_mid_stage.sv =====
// One midpoint stage: floor of the bound average and its full square.
// Depends on bsr_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "bisection_square_root_macros.svh"

module bsr_mid_stage
    import bsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_v,
    input  wire bnd_t in_d,
    output logic      out_v,
    output mid_t      out_d
);

    logic        valid_reg;
    logic        valid_next;
    mid_t        data_reg;
    mid_t        data_next;
    logic [DATA_W:0] sum;

    always_comb
    begin
        sum            = {1'b0, in_d.lo} + {1'b0, in_d.hi};
        data_next.mid  = sum[DATA_W:1];
        data_next.sq   = SQ_W'(data_next.mid) * SQ_W'(data_next.mid);
        data_next.lo   = in_d.lo;
        data_next.hi   = in_d.hi;
        data_next.x    = in_d.x;
        valid_next     = in_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_v = valid_reg;
    assign out_d = data_reg;

    `BSR_ASSERT_IMP(a_mid_in_bounds, clk, rst_n, valid_reg,
        (data_reg.mid >= data_reg.lo) && (data_reg.mid <= data_reg.hi))

endmodule

`default_nettype wire

// ===== rtl/bsr_cmp_stage.sv =====
// One compare stage: test the midpoint square against the scaled radicand
// and move one bound. Depends on bsr_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "bisection_square_root_macros.svh"

module bsr_cmp_stage
    import bsr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_v,
    input  wire mid_t in_d,
    output logic      out_v,
    output bnd_t      out_d
);

    logic            valid_reg;
    bnd_t            data_reg;
    bnd_t            data_next;
    logic [SQ_W-1:0] target;

    always_comb
    begin
        target      = SQ_W'(in_d.x) << FRACTION_BITS;
        data_next.x = in_d.x;
        if (in_d.sq < target)
        begin
            data_next.lo = in_d.mid;
            data_next.hi = in_d.hi;
        end
        else
        begin
            data_next.lo = in_d.lo;
            data_next.hi = in_d.mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_v = valid_reg;
    assign out_d = data_reg;

    `BSR_ASSERT_IMP(a_bounds_ordered, clk, rst_n, valid_reg, data_reg.lo <= data_reg.hi)

endmodule

`default_nettype wire

// ===== rtl/bsr_out_buf.sv =====
// Output register with one skid entry; the pipeline advances while the
// skid entry is empty. Depends on bsr_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "bisection_square_root_macros.svh"

module bsr_out_buf
    import bsr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tail_v,
    input  wire logic [DATA_W-1:0] tail_d,
    output logic                   pipe_en,
    output logic                   out_valid,
    output logic [DATA_W-1:0]      out_data,
    input  wire logic              out_ready
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg;
    logic [DATA_W-1:0] skid_data_next;
    logic              take;
    logic              push;

    assign take = out_valid_reg & out_ready;
    assign push = tail_v & ~skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // drain the skid entry into the output register
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = tail_d;
            end
            else
            begin
                // receiver stalled: park the beat
                skid_valid_next = 1'b1;
                skid_data_next  = tail_d;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign pipe_en   = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BSR_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `BSR_ASSERT_NXT(a_skid_kept, clk, rst_n, skid_valid_reg && !out_ready,
        skid_valid_reg && $stable(skid_data_reg))
    `BSR_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_valid_reg && out_ready,
        out_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire
